// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl file bse_seq.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define BSE_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define BSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bse_pkg.sv =====
// shared constants and types of the bubble sort block
package bse_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 12;

    // one word offered by the sequencer to the output stage
    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic [CNT_W-1:0]        count;
    } t_emit;

endpackage

// ===== rtl/bubble_sort_early_exit.sv =====
// top level of the bubble sort block with its output register
// Usage: words enter on i_valid/o_stall, one signed value each; i_is_last
// closes the set, and so does the DEPTH-th word of a set. While a set is
// still loading one word is taken per cycle.
// After the closing word the block sorts ascending with one shared
// compare-and-swap unit over a memory with one write and one read port.
// Each pass runs S_FETCH, S_CMP over each neighbouring pair, then S_TAIL;
// sorting of a set of n words ends after the first pass with no swap or
// after n-1 passes. Results leave on o_valid/i_stall in ascending order:
// each word is read through the registered memory read in S_ORD and
// offered in S_OLD, and a further word is read only after the previous
// one is taken; o_end_of_run marks the last and o_compare_count carries
// the number of comparisons with it, zero otherwise.
// o_stall is high from the closing word until the last result is in the
// output register. A stalled result holds in that register and the
// sequencer waits; the next set may load while the last result waits.
// Reset (synchronous, active low) empties the set and the output register;
// the memory needs no clearing.
module bubble_sort_early_exit #(
    parameter int DEPTH = bse_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [bse_pkg::VAL_W-1:0] i_value,
    input  logic                             i_is_last,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [bse_pkg::VAL_W-1:0] o_sorted_value,
    output logic                             o_end_of_run,
    output logic [bse_pkg::CNT_W-1:0]        o_compare_count
);

    bse_pkg::t_emit emit;
    logic           take;
    logic           r_valid;
    logic signed [bse_pkg::VAL_W-1:0] r_value;
    logic           r_end;
    logic [bse_pkg::CNT_W-1:0] r_cnt;

    bse_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_is_last   (i_is_last),
        .o_busy      (o_stall),
        .o_emit      (emit),
        .i_emit_take (take)
    );

    // load the output register when it is empty or being drained
    assign take = emit.valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_value <= emit.value;
            r_end   <= emit.last;
            r_cnt   <= emit.count;
        end
    end

    assign o_valid         = r_valid;
    assign o_sorted_value  = r_value;
    assign o_end_of_run    = r_end;
    assign o_compare_count = r_cnt;

endmodule

// ===== rtl/bse_cswap.sv =====
// signed compare-and-swap unit shared by every comparison of the sort
module bse_cswap (
    input  logic signed [bse_pkg::VAL_W-1:0] i_a,
    input  logic signed [bse_pkg::VAL_W-1:0] i_b,
    output logic                             o_gt,
    output logic signed [bse_pkg::VAL_W-1:0] o_lo,
    output logic signed [bse_pkg::VAL_W-1:0] o_hi
);

    // swap only on strictly greater, so equal words keep their order
    assign o_gt = i_a > i_b;
    assign o_lo = o_gt ? i_b : i_a;
    assign o_hi = o_gt ? i_a : i_b;

endmodule

// ===== rtl/bse_seq.sv =====
// sequencer, element memory and counters of the bubble sort
`include "assert_macros.svh"

module bse_seq #(
    parameter int DEPTH = bse_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [bse_pkg::VAL_W-1:0] i_value,
    input  logic                             i_is_last,
    output logic                             o_busy,
    output bse_pkg::t_emit                   o_emit,
    input  logic                             i_emit_take
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_CMP   = 6'b000100,
        S_TAIL  = 6'b001000,
        S_ORD   = 6'b010000,
        S_OLD   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pass, n_pass;
    logic [AW-1:0] r_k, n_k;
    logic signed [bse_pkg::VAL_W-1:0] r_carry, n_carry;
    logic r_swapped, n_swapped;
    logic [bse_pkg::CNT_W-1:0] r_tally, n_tally;
    logic signed [bse_pkg::VAL_W-1:0] r_rd_data;
    logic signed [bse_pkg::VAL_W-1:0] mem [DEPTH];

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic signed [bse_pkg::VAL_W-1:0] mem_wdata;

    logic          cs_gt;
    logic signed [bse_pkg::VAL_W-1:0] cs_lo, cs_hi;
    logic [CW-1:0] last_idx;
    logic [CW-1:0] k_ext;
    logic [CW-1:0] k_plus2;
    logic          out_last;

    assign last_idx = r_count - CW'(1);
    assign k_ext    = CW'(r_k);
    assign k_plus2  = k_ext + CW'(2);
    assign out_last = (k_ext == last_idx);
    assign o_busy   = (r_state != S_IDLE);

    // carried word against the next stored word
    bse_cswap u_cswap (
        .i_a  (r_carry),
        .i_b  (r_rd_data),
        .o_gt (cs_gt),
        .o_lo (cs_lo),
        .o_hi (cs_hi)
    );

    // word offered to the output stage
    always_comb begin
        o_emit.valid = (r_state == S_OLD);
        o_emit.value = r_rd_data;
        o_emit.last  = out_last;
        o_emit.count = out_last ? r_tally : '0;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pass    = r_pass;
        n_k       = r_k;
        n_carry   = r_carry;
        n_swapped = r_swapped;
        n_tally   = r_tally;
        mem_we    = 1'b0;
        mem_waddr = r_k;
        mem_wdata = cs_lo;
        mem_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[AW-1:0];
                    mem_wdata = i_value;
                    n_count   = r_count + CW'(1);
                    if (i_is_last || r_count == CW'(DEPTH - 1)) begin
                        n_pass  = '0;
                        n_tally = '0;
                        n_k     = '0;
                        n_state = (r_count == '0) ? S_ORD : S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_carry   = r_rd_data;
                n_k       = '0;
                n_swapped = 1'b0;
                mem_raddr = AW'(1);
                n_state   = S_CMP;
            end
            S_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = cs_lo;
                n_carry   = cs_hi;
                n_swapped = r_swapped | cs_gt;
                n_tally   = r_tally + bse_pkg::CNT_W'(1);
                if (k_ext + CW'(1) == last_idx) begin
                    n_state = S_TAIL;
                end else begin
                    mem_raddr = k_plus2[AW-1:0];
                    n_k       = r_k + AW'(1);
                end
            end
            S_TAIL: begin
                mem_we    = 1'b1;
                mem_waddr = last_idx[AW-1:0];
                mem_wdata = r_carry;
                n_pass    = r_pass + CW'(1);
                if (!r_swapped || r_pass + CW'(1) == last_idx) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_ORD: begin
                mem_raddr = r_k;
                n_state   = S_OLD;
            end
            S_OLD: begin
                mem_raddr = r_k;
                if (i_emit_take) begin
                    if (out_last) begin
                        n_count = '0;
                        n_tally = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pass    <= '0;
            r_k       <= '0;
            r_swapped <= 1'b0;
            r_tally   <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pass    <= n_pass;
            r_k       <= n_k;
            r_swapped <= n_swapped;
            r_tally   <= n_tally;
        end
    end

    // carried word
    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    // element memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    `BSE_ASSERT(a_cmp_in_set, i_clk, i_rst_n, r_state == S_CMP,
                k_ext + CW'(1) < r_count, "compare beyond the set")
    `BSE_ASSERT_NEXT(a_clean_pass_ends, i_clk, i_rst_n, r_state == S_TAIL && !r_swapped,
                     r_state == S_ORD, "clean pass did not end the sort")
    `BSE_ASSERT(a_idle_count, i_clk, i_rst_n, r_state == S_IDLE,
                r_count < CW'(DEPTH), "store overfilled while loading")

endmodule
